/* rtl/sobel_edge_magnitude_core_assert.svh */
// Assertion macros shared by the checker files of the edge magnitude core.
`ifndef SOBEL_EDGE_MAGNITUDE_CORE_ASSERT_SVH
`define SOBEL_EDGE_MAGNITUDE_CORE_ASSERT_SVH

// Same-cycle implication, off while reset is high.
`define SEM_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off while reset is high.
`define SEM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Implication that also holds through reset.
`define SEM_ASSERT_ALWAYS(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
      else $error(msg);

`endif

/* rtl/sem_pkg.sv */
package sem_pkg;

   // Line store depth and derived counter widths
   localparam int MAX_WIDTH = 2048;
   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int CNT_W     = $clog2(MAX_WIDTH + 1);

   // Fixed field widths
   localparam int WIDTH_W = 12;
   localparam int PIX_W   = 8;
   localparam int GRAD_W  = 10;
   localparam int MAG_W   = 8;
   localparam int SUM_W   = GRAD_W + 1;

   localparam int MIN_WIDTH = 3;
   localparam logic [WIDTH_W-1:0] RESET_WIDTH = WIDTH_W'(640);
   localparam logic [1:0]         ROWS_FULL   = 2'd2;
   localparam int                 FIRST_COL   = 2;
   localparam logic [SUM_W-1:0]   MAG_MAX     = SUM_W'(255);

   typedef struct packed {
      logic [PIX_W-1:0] upper;
      logic [PIX_W-1:0] middle;
   } ls_word_type;

   typedef struct packed {
      logic             en;
      logic [COL_W-1:0] addr;
   } ls_rd_type;

   typedef struct packed {
      logic             en;
      logic [COL_W-1:0] addr;
      ls_word_type      data;
   } ls_wr_type;

   // Clamp a programmed row width to the supported range
   function automatic logic [CNT_W-1:0] clamp_width(input logic [WIDTH_W-1:0] w);
      logic [CNT_W-1:0] r;
      if (int'(w) < MIN_WIDTH) begin
         r = CNT_W'(MIN_WIDTH);
      end else if (int'(w) > MAX_WIDTH) begin
         r = CNT_W'(MAX_WIDTH);
      end else begin
         r = CNT_W'(w);
      end
      return r;
   endfunction

endpackage

/* rtl/sem_channels.sv */
// Pixel input channel
interface sem_req_if;
   logic                      valid;
   logic                      ready;
   logic [sem_pkg::PIX_W-1:0] pixel_value;
   logic                      start_of_frame;

   modport source (output valid, output pixel_value, output start_of_frame, input ready);
   modport sink   (input valid, input pixel_value, input start_of_frame, output ready);
endinterface

// Gradient result channel
interface sem_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [sem_pkg::MAG_W-1:0]  edge_magnitude;
   logic [sem_pkg::GRAD_W-1:0] horizontal_gradient;
   logic [sem_pkg::GRAD_W-1:0] vertical_gradient;
   logic                       window_valid;

   modport source (output valid, output edge_magnitude, output horizontal_gradient,
                   output vertical_gradient, output window_valid, input ready);
   modport sink   (input valid, input edge_magnitude, input horizontal_gradient,
                   input vertical_gradient, input window_valid, output ready);
endinterface

/* rtl/sem_line_store.sv */
// Two line stores packed into one word-wide memory, with a registered read.
// Entries past the highest column ever written read as zero; a read that
// meets a write to the same entry in the same cycle takes the written word.
module sem_line_store (
   input  logic                 clock,
   input  logic                 reset,
   input  sem_pkg::ls_rd_type   rd,
   input  sem_pkg::ls_wr_type   wr,
   output sem_pkg::ls_word_type rd_data
);

   sem_pkg::ls_word_type mem [sem_pkg::MAX_WIDTH];

   sem_pkg::ls_word_type           q_ff;
   sem_pkg::ls_word_type           fwd_data_ff;
   logic                           fwd_ff;
   logic                           hit_ff;
   logic [sem_pkg::CNT_W-1:0]      fill_ff;
   logic [sem_pkg::CNT_W-1:0]      fill_in;

   // Write port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // Read port, held between reads
   always_ff @(posedge clock) begin
      if (rd.en) begin
         q_ff        <= mem[rd.addr];
         fwd_data_ff <= wr.data;
      end
   end

   // Extend the written range; columns are written in order from zero
   always_comb begin
      fill_in = fill_ff;
      if (wr.en && (sem_pkg::CNT_W'(wr.addr) >= fill_ff)) begin
         fill_in = sem_pkg::CNT_W'(wr.addr) + sem_pkg::CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         fwd_ff  <= 1'b0;
         hit_ff  <= 1'b0;
      end else begin
         fill_ff <= fill_in;
         if (rd.en) begin
            fwd_ff <= wr.en && (wr.addr == rd.addr);
            hit_ff <= sem_pkg::CNT_W'(rd.addr) < fill_ff;
         end
      end
   end

   // Select forwarded, stored or reset value
   always_comb begin
      if (fwd_ff) begin
         rd_data = fwd_data_ff;
      end else if (hit_ff) begin
         rd_data = q_ff;
      end else begin
         rd_data = '0;
      end
   end

endmodule

/* rtl/sobel_edge_magnitude_core.sv */
// 3x3 Sobel edge magnitude on a raster pixel stream. One pixel is taken per
// clock unless a held result stalls on rsp.ready, and one result is given per
// pixel. Each result passes the registered read of the line store memory
// and then the gradient result register. The two previous rows live
// in a single memory of MAX_WIDTH words (upper and middle row side by side);
// the column is read when a pixel is taken and written back when its result
// is formed, with same-entry forwarding. No clearing pass runs after reset:
// a fill count makes never-written columns read as zero, so pixels are taken
// from the first cycle out of reset. The row width is written on csr_wr_en
// and clamped to 3..MAX_WIDTH; start_of_frame clears the row and column count.
module sobel_edge_magnitude_core (
   input  logic                        clock,
   input  logic                        reset,
   sem_req_if.sink                     req,
   sem_rsp_if.source                   rsp,
   input  logic                        csr_wr_en,
   input  logic [sem_pkg::WIDTH_W-1:0] csr_wr_data
);

   // Configuration
   logic [sem_pkg::CNT_W-1:0] width_ff;

   // Frame position
   logic [sem_pkg::COL_W-1:0] col_ff;
   logic [sem_pkg::COL_W-1:0] col_in;
   logic [1:0]                rows_ff;
   logic [1:0]                rows_in;
   logic [sem_pkg::COL_W-1:0] col_base;
   logic [sem_pkg::COL_W-1:0] col_cur;
   logic [1:0]                rows_base;
   logic [sem_pkg::CNT_W-1:0] col_next;
   logic                      win_cur;
   logic                      req_fire;

   // Window stage
   logic                      s1_valid_ff;
   logic [sem_pkg::COL_W-1:0] s1_col_ff;
   logic [sem_pkg::PIX_W-1:0] s1_pix_ff;
   logic                      s1_win_ff;
   logic                      s1_go;
   logic                      s1_ready;

   // Window columns: two back (w0..w2) and one back (w3..w5), top to bottom
   logic [sem_pkg::PIX_W-1:0] win_ff [6];

   sem_pkg::ls_rd_type   ls_rd;
   sem_pkg::ls_wr_type   ls_wr;
   sem_pkg::ls_word_type ls_q;

   // Gradients
   logic [sem_pkg::GRAD_W-1:0] sum_l, sum_r, sum_t, sum_b;
   logic [sem_pkg::GRAD_W-1:0] gx, gy;
   logic [sem_pkg::SUM_W-1:0]  mag_sum;
   logic [sem_pkg::MAG_W-1:0]  mag;

   // Result register
   logic                       rsp_valid_ff;
   logic [sem_pkg::MAG_W-1:0]  rsp_mag_ff;
   logic [sem_pkg::GRAD_W-1:0] rsp_gx_ff;
   logic [sem_pkg::GRAD_W-1:0] rsp_gy_ff;
   logic                       rsp_win_ff;

   // Hold the clamped row width
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= sem_pkg::clamp_width(sem_pkg::RESET_WIDTH);
      end else if (csr_wr_en) begin
         width_ff <= sem_pkg::clamp_width(csr_wr_data);
      end
   end

   // Handshake
   assign s1_go    = s1_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign s1_ready = !s1_valid_ff || s1_go;
   assign req_fire = req.valid && s1_ready;
   assign req.ready = s1_ready;

   // Column and row of the incoming pixel, and the position after it
   always_comb begin
      col_base  = req.start_of_frame ? '0 : col_ff;
      rows_base = req.start_of_frame ? 2'd0 : rows_ff;
      col_cur   = (sem_pkg::CNT_W'(col_base) >= width_ff) ? '0 : col_base;
      col_next  = sem_pkg::CNT_W'(col_cur) + sem_pkg::CNT_W'(1);
      win_cur   = (rows_base >= sem_pkg::ROWS_FULL) &&
                  (int'(col_cur) >= sem_pkg::FIRST_COL);
      col_in    = col_next[sem_pkg::COL_W-1:0];
      rows_in   = rows_base;
      if (col_next >= width_ff) begin
         col_in = '0;
         if (rows_base < sem_pkg::ROWS_FULL) begin
            rows_in = rows_base + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         rows_ff <= 2'd0;
      end else if (req_fire) begin
         col_ff  <= col_in;
         rows_ff <= rows_in;
      end
   end

   // Advance the pixel into the window stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_col_ff <= col_cur;
         s1_pix_ff <= req.pixel_value;
         s1_win_ff <= win_cur;
      end
   end

   // Line store access: read on accept, write back as the result forms
   always_comb begin
      ls_rd.en          = req_fire;
      ls_rd.addr        = col_cur;
      ls_wr.en          = s1_go;
      ls_wr.addr        = s1_col_ff;
      ls_wr.data.upper  = ls_q.middle;
      ls_wr.data.middle = s1_pix_ff;
   end

   sem_line_store u_line_store (
      .clock   (clock),
      .reset   (reset),
      .rd      (ls_rd),
      .wr      (ls_wr),
      .rd_data (ls_q)
   );

   // Shift the window columns
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (s1_go) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= ls_q.upper;
         win_ff[4] <= ls_q.middle;
         win_ff[5] <= s1_pix_ff;
      end
   end

   // Weighted column and row sums, absolute differences, saturated sum
   always_comb begin
      sum_l = sem_pkg::GRAD_W'(win_ff[0]) + (sem_pkg::GRAD_W'(win_ff[1]) << 1) +
              sem_pkg::GRAD_W'(win_ff[2]);
      sum_r = sem_pkg::GRAD_W'(ls_q.upper) + (sem_pkg::GRAD_W'(ls_q.middle) << 1) +
              sem_pkg::GRAD_W'(s1_pix_ff);
      sum_t = sem_pkg::GRAD_W'(win_ff[0]) + (sem_pkg::GRAD_W'(win_ff[3]) << 1) +
              sem_pkg::GRAD_W'(ls_q.upper);
      sum_b = sem_pkg::GRAD_W'(win_ff[2]) + (sem_pkg::GRAD_W'(win_ff[5]) << 1) +
              sem_pkg::GRAD_W'(s1_pix_ff);
      gx = (sum_l >= sum_r) ? (sum_l - sum_r) : (sum_r - sum_l);
      gy = (sum_t >= sum_b) ? (sum_t - sum_b) : (sum_b - sum_t);
      mag_sum = sem_pkg::SUM_W'(gx) + sem_pkg::SUM_W'(gy);
      mag = (mag_sum > sem_pkg::MAG_MAX) ? sem_pkg::MAG_MAX[sem_pkg::MAG_W-1:0]
                                         : mag_sum[sem_pkg::MAG_W-1:0];
   end

   // Result register: load on advance, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         rsp_win_ff <= s1_win_ff;
         rsp_mag_ff <= s1_win_ff ? mag : '0;
         rsp_gx_ff  <= s1_win_ff ? gx : '0;
         rsp_gy_ff  <= s1_win_ff ? gy : '0;
      end
   end

   assign rsp.valid               = rsp_valid_ff;
   assign rsp.edge_magnitude      = rsp_mag_ff;
   assign rsp.horizontal_gradient = rsp_gx_ff;
   assign rsp.vertical_gradient   = rsp_gy_ff;
   assign rsp.window_valid        = rsp_win_ff;

endmodule

/* rtl/sem_checker.sv */
`include "sobel_edge_magnitude_core_assert.svh"

// Port-level checks on the edge magnitude core
module sem_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [sem_pkg::MAG_W-1:0]  edge_magnitude,
   input logic [sem_pkg::GRAD_W-1:0] horizontal_gradient,
   input logic [sem_pkg::GRAD_W-1:0] vertical_gradient,
   input logic                       window_valid
);

   logic [sem_pkg::SUM_W-1:0] grad_sum;
   logic [sem_pkg::MAG_W-1:0] grad_sat;

   assign grad_sum = sem_pkg::SUM_W'(horizontal_gradient) + sem_pkg::SUM_W'(vertical_gradient);
   assign grad_sat = (grad_sum > sem_pkg::MAG_MAX) ? sem_pkg::MAG_MAX[sem_pkg::MAG_W-1:0]
                                                   : grad_sum[sem_pkg::MAG_W-1:0];

   // A stalled result beat holds its magnitude
   `SEM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(edge_magnitude), "stalled result beat changed")

   // Partial windows give all-zero gradients
   `SEM_ASSERT_IMPL(a_border_zero, clock, reset, rsp_valid && !window_valid, (edge_magnitude == '0) && (horizontal_gradient == '0) && (vertical_gradient == '0), "border result not zero")

   // Magnitude is the saturated sum of the two gradients
   `SEM_ASSERT_IMPL(a_mag_sum, clock, reset, rsp_valid && window_valid, edge_magnitude == grad_sat, "magnitude does not match gradients")

   // No result right after reset
   `SEM_ASSERT_ALWAYS(a_reset_empty, clock, $past(reset), !rsp_valid, "result valid after reset")

endmodule

bind sobel_edge_magnitude_core sem_checker u_sem_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp.valid),
   .rsp_ready           (rsp.ready),
   .edge_magnitude      (rsp.edge_magnitude),
   .horizontal_gradient (rsp.horizontal_gradient),
   .vertical_gradient   (rsp.vertical_gradient),
   .window_valid        (rsp.window_valid)
);
